// ===== rtl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg: shared types, constants and the Morse code table
// Symbol codes, result and batch types, and the code lookup function used by
// the packed Morse stream decoder.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int unsigned CODE_MAX_LEN = 7;
    localparam int unsigned KEY_W        = CODE_MAX_LEN + 1;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned SYM_PER_BYTE = 4;
    localparam int unsigned MAX_RES      = 5;
    localparam int unsigned CNT_W        = 3;
    localparam int unsigned CHAR_W       = 7;

    localparam logic [KEY_W-1:0]  KEY_EMPTY  = KEY_W'(1);
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 7'h09;

    typedef enum logic [1:0] {
        SYM_LGAP = 2'b00,
        SYM_DASH = 2'b01,
        SYM_DOT  = 2'b10,
        SYM_WGAP = 2'b11
    } t_sym;

    typedef struct packed {
        logic              unknown;
        logic [CHAR_W-1:0] ch;
    } t_res;

    typedef struct packed {
        logic [CNT_W-1:0]       cnt;
        t_res [MAX_RES-1:0]     ent;
    } t_batch;

    // The key is a leading one followed by the symbols in arrival order,
    // a dash as one and a dot as zero.
    function automatic t_res code_lookup(input logic [KEY_W-1:0] key);
        t_res r;
        r.unknown = 1'b0;
        unique case (key)
            8'b0000001_0: r.ch = 7'h45;
            8'b0000001_1: r.ch = 7'h54;
            8'b000001_01: r.ch = 7'h41;
            8'b000001_10: r.ch = 7'h4E;
            8'b000001_11: r.ch = 7'h4D;
            8'b000001_00: r.ch = 7'h49;
            8'b00001_111: r.ch = 7'h4F;
            8'b00001_110: r.ch = 7'h47;
            8'b00001_101: r.ch = 7'h4B;
            8'b00001_100: r.ch = 7'h44;
            8'b00001_011: r.ch = 7'h57;
            8'b00001_010: r.ch = 7'h52;
            8'b00001_001: r.ch = 7'h55;
            8'b00001_000: r.ch = 7'h53;
            8'b0001_1101: r.ch = 7'h51;
            8'b0001_1011: r.ch = 7'h59;
            8'b0001_1010: r.ch = 7'h43;
            8'b0001_0001: r.ch = 7'h56;
            8'b0001_1001: r.ch = 7'h58;
            8'b0001_1100: r.ch = 7'h5A;
            8'b0001_0000: r.ch = 7'h48;
            8'b0001_0010: r.ch = 7'h46;
            8'b0001_0100: r.ch = 7'h4C;
            8'b0001_0110: r.ch = 7'h50;
            8'b0001_0111: r.ch = 7'h4A;
            8'b0001_1000: r.ch = 7'h42;
            8'b0001_0101: r.ch = 7'h5D;
            8'b0001_0011: r.ch = CHAR_SPACE;
            8'b0001_1110: r.ch = CHAR_SPACE;
            8'b0001_1111: r.ch = CHAR_SPACE;
            8'b001_01111: r.ch = 7'h31;
            8'b001_00111: r.ch = 7'h32;
            8'b001_00011: r.ch = 7'h33;
            8'b001_00001: r.ch = 7'h34;
            8'b001_00000: r.ch = 7'h35;
            8'b001_10000: r.ch = 7'h36;
            8'b001_11000: r.ch = 7'h37;
            8'b001_11100: r.ch = 7'h38;
            8'b001_11110: r.ch = 7'h39;
            8'b001_11111: r.ch = 7'h30;
            8'b001_00110: r.ch = 7'h21;
            8'b001_10001: r.ch = 7'h3D;
            8'b001_01010: r.ch = 7'h2B;
            8'b001_10010: r.ch = 7'h2A;
            8'b001_10110: r.ch = 7'h28;
            8'b001_01000: r.ch = 7'h26;
            8'b001_11001: r.ch = CHAR_SPACE;
            8'b001_01001: r.ch = CHAR_SPACE;
            8'b001_01101: r.ch = CHAR_SPACE;
            8'b001_10101: r.ch = CHAR_SPACE;
            8'b001_00010: r.ch = CHAR_SPACE;
            8'b001_10100: r.ch = CHAR_SPACE;
            8'b01_010101: r.ch = 7'h2E;
            8'b01_110011: r.ch = 7'h2C;
            8'b01_001100: r.ch = 7'h3F;
            8'b01_111000: r.ch = 7'h3A;
            8'b01_010010: r.ch = 7'h22;
            8'b01_011110: r.ch = 7'h27;
            8'b01_100001: r.ch = 7'h2D;
            8'b01_101101: r.ch = 7'h29;
            8'b01_011010: r.ch = 7'h40;
            8'b01_001101: r.ch = 7'h5F;
            8'b01_101010: r.ch = 7'h3B;
            8'b01_000101: r.ch = 7'h23;
            8'b01_101001: r.ch = 7'h25;
            8'b01_000100: r.ch = CHAR_SPACE;
            8'b1_0001001: r.ch = 7'h24;
            default: begin
                r.unknown = 1'b1;
                r.ch      = CHAR_TAB;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/packed_morse_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// packed_morse_stream_decoder: packed Morse symbol stream to characters
// Splits each byte into four Morse symbols and emits the decoded characters.
//
//   Channel   Dir  tdata (low bit up)     tuser          tlast
//   s_axis    in   in_byte[7:0]           -              -
//   m_axis    out  out_char[6:0], 0       unknown_code   last_of_run
//
// A byte enters the input register, is decoded combinationally and its zero to
// five results load the result register once the emitter is free.
// Results leave one beat per cycle while m_axis_tready is high; the next batch
// loads as the last beat of the current batch is taken.
// Reset is synchronous and active low and clears the pending code.
// Output stalls hold the result register; while a batch drains, a byte with results waits in the input register.
// ----------------------------------------------------------------------------
module packed_morse_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_char[6:0], zero pad
    output logic        m_axis_tuser,   // unknown_code
    output logic        m_axis_tlast
);
    import msd_pkg::*;

    logic              free;
    logic              bvalid;
    t_batch            batch;
    logic [CHAR_W-1:0] out_char;

    msd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_free   (free),
        .o_bvalid (bvalid),
        .o_batch  (batch)
    );

    msd_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bvalid  (bvalid),
        .i_batch   (batch),
        .o_free    (free),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_char    (out_char),
        .o_unknown (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

// ===== rtl/msd_decode.sv =====
// ----------------------------------------------------------------------------
// msd_decode: input register, code state and per-byte decode
// Holds one byte, walks its four symbols against the pending code and
// presents the batch of results that the byte causes.
// ----------------------------------------------------------------------------
module msd_decode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_tvalid,
    output logic                                o_tready,
    input  logic [msd_pkg::BYTE_W-1:0]          i_tdata,
    input  logic                                i_free,
    output logic                                o_bvalid,
    output msd_pkg::t_batch                     o_batch
);
    import msd_pkg::*;

    logic                r_vld;
    logic [BYTE_W-1:0]   r_byte;
    logic [KEY_W-1:0]    r_key;
    logic                r_over;
    logic [KEY_W-1:0]    n_key;
    logic                n_over;
    logic                adv;
    t_batch              batch;

    always_comb begin
        logic [KEY_W-1:0] key;
        logic             over;
        logic [CNT_W-1:0] n;
        t_sym             sym;
        key   = r_key;
        over  = r_over;
        n     = '0;
        batch = '0;
        for (int i = 0; i < SYM_PER_BYTE; i++) begin
            sym = t_sym'(r_byte[2*i +: 2]);
            unique case (sym)
                SYM_LGAP, SYM_WGAP: begin
                    if (key != KEY_EMPTY || over) begin
                        if (over) begin
                            batch.ent[n] = '{unknown: 1'b1, ch: CHAR_TAB};
                        end else begin
                            batch.ent[n] = code_lookup(key);
                        end
                        n    = n + CNT_W'(1);
                        key  = KEY_EMPTY;
                        over = 1'b0;
                    end
                    if (sym == SYM_WGAP) begin
                        batch.ent[n] = '{unknown: 1'b0, ch: CHAR_SPACE};
                        n            = n + CNT_W'(1);
                    end
                end
                SYM_DOT, SYM_DASH: begin
                    if (key[KEY_W-1]) begin
                        over = 1'b1;
                    end else begin
                        key = {key[KEY_W-2:0], sym == SYM_DASH};
                    end
                end
            endcase
        end
        batch.cnt = n;
        n_key     = key;
        n_over    = over;
    end

    assign adv      = r_vld && (batch.cnt == '0 || i_free);
    assign o_tready = !r_vld || adv;
    assign o_bvalid = r_vld && batch.cnt != '0;
    assign o_batch  = batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_key  <= KEY_EMPTY;
            r_over <= 1'b0;
        end else begin
            if (adv) begin
                r_key  <= n_key;
                r_over <= n_over;
            end
            if (o_tready) begin
                r_vld <= i_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_byte <= i_tdata;
        end
    end

endmodule

// ===== rtl/msd_emit.sv =====
// ----------------------------------------------------------------------------
// msd_emit: result register and beat sequencer
// Stores one batch of results and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module msd_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_bvalid,
    input  msd_pkg::t_batch                 i_batch,
    output logic                            o_free,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [msd_pkg::CHAR_W-1:0]      o_char,
    output logic                            o_unknown,
    output logic                            o_last
);
    import msd_pkg::*;

    t_res [MAX_RES-1:0]  r_ent;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_idx;
    logic                beat;
    logic                load;

    assign o_tvalid  = r_cnt != '0;
    assign o_last    = r_idx == r_cnt - CNT_W'(1);
    assign o_char    = r_ent[r_idx].ch;
    assign o_unknown = r_ent[r_idx].unknown;
    assign beat      = o_tvalid && i_tready;
    assign o_free    = !o_tvalid || (beat && o_last);
    assign load      = o_free && i_bvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (load) begin
            r_cnt <= i_batch.cnt;
            r_idx <= '0;
        end else if (beat) begin
            if (o_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ent <= i_batch.ent;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RES))
        else $error("batch count beyond five results");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid |-> r_idx < r_cnt)
        else $error("beat index outside the batch");

    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat && !o_last |=> o_tvalid)
        else $error("batch ended before its last beat");

    a_unknown_tab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && o_unknown |-> o_char == CHAR_TAB)
        else $error("unknown flag on a character other than tab");

endmodule
